// File: hdl/http_chunked_end_detector_unit_defines.svh
// Assertion macros used by the chunked end detector top level.
`ifndef HTTP_CHUNKED_END_DETECTOR_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_END_DETECTOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCED_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCED_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: hdl/hced_pkg.sv
// Types, constants and helper functions of the chunked end detector.
package hced_pkg;

   localparam int SIZE_BITS = 32;

   typedef logic [SIZE_BITS-1:0] size_type;

   localparam size_type SIZE_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

   localparam logic [7:0] CR = 8'h0D;
   localparam logic [7:0] LF = 8'h0A;
   localparam logic [2:0] KEYWORD_LEN = 3'd7;
   localparam logic [2:0] KEYWORD_FIRST = 3'd0;
   localparam logic [1:0] BLANK_LAST = 2'd3;
   localparam logic [1:0] TRAILER_LEN = 2'd2;

   typedef enum logic [5:0] {
      PH_HEADER  = 6'b000001,
      PH_SIZE    = 6'b000010,
      PH_EXT     = 6'b000100,
      PH_DATA    = 6'b001000,
      PH_TRAILER = 6'b010000,
      PH_BODY    = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  blank_line_match;
      logic [2:0]  keyword_match;
      logic        is_chunked;
      size_type    size_accum;
      size_type    data_remaining;
      logic [1:0]  trailer_count;
      logic        done_flag;
   } state_type;

   typedef struct packed {
      logic finished;
      logic header_done;
      logic chunked_mode;
      logic payload_valid;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h63;
         3'd1: ch = 8'h68;
         3'd2: ch = 8'h75;
         3'd3: ch = 8'h6E;
         3'd4: ch = 8'h6B;
         3'd5: ch = 8'h65;
         3'd6: ch = 8'h64;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] blank_char(input logic [1:0] idx);
      return idx[0] ? LF : CR;
   endfunction

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (b inside {[8'h30:8'h39]}) begin
         h.value = 4'(b - 8'h30);
      end else if (b inside {[8'h61:8'h66]}) begin
         h.value = 4'(b - 8'h57);
      end else if (b inside {[8'h41:8'h46]}) begin
         h.value = 4'(b - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// File: hdl/hced_if.sv
// Request and response channel interfaces of the chunked end detector.
interface hced_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       conn_closed;

   modport source (output valid, output rx_byte, output conn_closed, input ready);
   modport sink (input valid, input rx_byte, input conn_closed, output ready);
endinterface

interface hced_rsp_if;
   logic valid;
   logic ready;
   logic finished;
   logic header_done;
   logic chunked_mode;
   logic payload_valid;

   modport source (output valid, output finished, output header_done,
                   output chunked_mode, output payload_valid, input ready);
   modport sink (input valid, input finished, input header_done,
                 input chunked_mode, input payload_valid, output ready);
endinterface

// File: hdl/http_chunked_end_detector_unit.sv
// Top level of the HTTP chunked response end detector.
// A request's response becomes valid once it has passed the input register and then the output register.
// Throughput: one request per cycle; the input and output registers each stall
// only when the stage after them is full.
// Reset is synchronous and clears the parser state and both stage valid flags.
`include "http_chunked_end_detector_unit_defines.svh"

module http_chunked_end_detector_unit (
   input logic       clock,
   input logic       reset,
   hced_req_if.sink  req_bus,
   hced_rsp_if.source rsp_bus
);

   hced_pkg::state_type  state_ff, state_in;
   hced_pkg::result_type res_in, res_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_closed_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 req_ready;

   hced_step u_step (
      .cur         (state_ff),
      .rx_byte     (in_byte_ff),
      .conn_closed (in_closed_ff),
      .nxt         (state_in),
      .res         (res_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_ready = !in_valid_ff || advance;

   assign req_bus.ready = req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_bus.valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
         state_ff.phase             <= hced_pkg::PH_HEADER;
         state_ff.blank_line_match  <= 2'd0;
         state_ff.keyword_match     <= 3'd0;
         state_ff.is_chunked        <= 1'b0;
         state_ff.size_accum        <= '0;
         state_ff.data_remaining    <= '0;
         state_ff.trailer_count     <= 2'd0;
         state_ff.done_flag         <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_bus.valid) begin
         in_byte_ff   <= req_bus.rx_byte;
         in_closed_ff <= req_bus.conn_closed;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.finished      = res_ff.finished;
   assign rsp_bus.header_done   = res_ff.header_done;
   assign rsp_bus.chunked_mode  = res_ff.chunked_mode;
   assign rsp_bus.payload_valid = res_ff.payload_valid;

   `HCED_ASSERT_NEXT(a_done_sticky, clock, reset, state_ff.done_flag,
      state_ff.done_flag, "completion flag dropped")
   `HCED_ASSERT_NOW(a_data_nonzero, clock, reset, state_ff.phase == hced_pkg::PH_DATA,
      state_ff.data_remaining != '0, "data phase with no bytes left")
   `HCED_ASSERT_NOW(a_payload_chunked, clock, reset, rsp_bus.valid && rsp_bus.payload_valid,
      rsp_bus.chunked_mode && !rsp_bus.finished, "payload outside an open chunked body")

endmodule

// File: hdl/hced_step.sv
// Per-byte parser update: next state and result for one received byte.
module hced_step (
   input  hced_pkg::state_type  cur,
   input  logic [7:0]           rx_byte,
   input  logic                 conn_closed,
   output hced_pkg::state_type  nxt,
   output hced_pkg::result_type res
);

   logic [2:0]        kw;
   logic              chunk;
   logic              payload;
   hced_pkg::hex_type hex;
   hced_pkg::size_type rem;
   logic [1:0]        tc;

   always_comb begin
      nxt     = cur;
      kw      = cur.keyword_match;
      chunk   = cur.is_chunked;
      payload = 1'b0;
      hex     = hced_pkg::hex_digit(rx_byte);
      rem     = cur.data_remaining;
      tc      = cur.trailer_count;
      if (!cur.done_flag) begin
         if (conn_closed) begin
            nxt.done_flag = 1'b1;
         end else begin
            case (cur.phase)
               hced_pkg::PH_HEADER: begin
                  if (!cur.is_chunked) begin
                     if (rx_byte == hced_pkg::keyword_char(cur.keyword_match)) begin
                        kw = cur.keyword_match + 3'd1;
                     end else begin
                        kw = (rx_byte == hced_pkg::keyword_char(hced_pkg::KEYWORD_FIRST))
                           ? 3'd1 : 3'd0;
                     end
                     if (kw == hced_pkg::KEYWORD_LEN) begin
                        chunk = 1'b1;
                        kw    = 3'd0;
                     end
                     nxt.keyword_match = kw;
                     nxt.is_chunked    = chunk;
                  end
                  if (rx_byte == hced_pkg::blank_char(cur.blank_line_match)) begin
                     if (cur.blank_line_match == hced_pkg::BLANK_LAST) begin
                        nxt.blank_line_match = 2'd0;
                        nxt.phase      = chunk ? hced_pkg::PH_SIZE : hced_pkg::PH_BODY;
                        nxt.size_accum = '0;
                     end else begin
                        nxt.blank_line_match = cur.blank_line_match + 2'd1;
                     end
                  end else begin
                     nxt.blank_line_match = (rx_byte == hced_pkg::CR) ? 2'd1 : 2'd0;
                  end
               end
               hced_pkg::PH_SIZE: begin
                  if (hex.valid) begin
                     if (|cur.size_accum[hced_pkg::SIZE_BITS-1 -: 4]) begin
                        nxt.size_accum = '1;
                     end else begin
                        nxt.size_accum = {cur.size_accum[hced_pkg::SIZE_BITS-5:0], hex.value};
                     end
                  end else if (cur.size_accum == '0) begin
                     nxt.done_flag = 1'b1;
                  end else begin
                     nxt.data_remaining = cur.size_accum;
                     nxt.phase = (rx_byte == hced_pkg::LF) ? hced_pkg::PH_DATA
                                                           : hced_pkg::PH_EXT;
                  end
               end
               hced_pkg::PH_EXT: begin
                  if (rx_byte == hced_pkg::LF) begin
                     nxt.phase = hced_pkg::PH_DATA;
                  end
               end
               hced_pkg::PH_DATA: begin
                  payload = 1'b1;
                  if (cur.data_remaining != '0) begin
                     rem = cur.data_remaining - hced_pkg::SIZE_ONE;
                  end
                  nxt.data_remaining = rem;
                  if (rem == '0) begin
                     nxt.phase         = hced_pkg::PH_TRAILER;
                     nxt.trailer_count = 2'd0;
                  end
               end
               hced_pkg::PH_TRAILER: begin
                  tc = cur.trailer_count + 2'd1;
                  if (tc >= hced_pkg::TRAILER_LEN) begin
                     tc             = 2'd0;
                     nxt.size_accum = '0;
                     nxt.phase      = hced_pkg::PH_SIZE;
                  end
                  nxt.trailer_count = tc;
               end
               default: begin
               end
            endcase
         end
      end
      res.finished      = nxt.done_flag;
      res.header_done   = (nxt.phase != hced_pkg::PH_HEADER);
      res.chunked_mode  = nxt.is_chunked;
      res.payload_valid = payload;
   end

endmodule
